// ----- design/scp_pkg.sv -----
`default_nettype none
package scp_pkg;

	localparam int AngleW = 32;
	localparam int ValueW = 32;
	localparam int ArgW   = 30;
	localparam int AccW   = 32;
	localparam int ProdW  = AccW + ArgW + 1;
	localparam int FracW  = 29;
	localparam int NCoef  = 8;

	localparam logic signed [AngleW-1:0] PI_Q29      = 32'sd1686629713;
	localparam logic signed [AngleW-1:0] HALF_PI_Q29 = 32'sd843314857;
	localparam logic signed [AccW-1:0]   ONE_Q30     = 32'sd1073741824;

	// Coefficients in Q.30, highest power first.
	localparam logic signed [AccW-1:0] COEF [NCoef] = '{
		-32'sd147886, -32'sd219591, 32'sd9276365, -32'sd261228,
		-32'sd178844898, -32'sd24029, 32'sd1073743896, -32'sd38
	};

	// One word in flight along the Horner chain.
	typedef struct packed {
		logic                   valid;
		logic                   neg;
		logic [ArgW-1:0]        x;
		logic signed [AccW-1:0] u;
	} scp_word_t;

endpackage
`default_nettype wire

// ----- design/scp_fold.sv -----
`default_nettype none
module scp_fold
	import scp_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     valid,
	input  wire logic                     kind,
	input  wire logic signed [AngleW-1:0] angle,
	output scp_word_t                     word
);

	logic signed [AngleW-1:0] clamped;
	logic [AngleW-2:0]        mag;
	logic [AngleW-2:0]        folded;
	logic [AngleW-2:0]        arg;
	logic                     over_half;
	logic                     neg;
	logic                     valid_s1;
	logic                     neg_s1;
	logic [ArgW-1:0]          x_s1;

	always_comb begin
		priority if (angle > PI_Q29) begin
			clamped = PI_Q29;
		end else if (angle < -PI_Q29) begin
			clamped = -PI_Q29;
		end else begin
			clamped = angle;
		end
		mag       = clamped[AngleW-1] ? (AngleW-1)'(-clamped) : clamped[AngleW-2:0];
		over_half = mag > HALF_PI_Q29[AngleW-2:0];
		folded    = over_half ? PI_Q29[AngleW-2:0] - mag : mag;
		if (kind) begin
			// Cosine runs the sine polynomial at pi/2 minus the folded angle.
			neg = over_half;
			arg = HALF_PI_Q29[AngleW-2:0] - folded;
		end else begin
			neg = clamped[AngleW-1];
			arg = folded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= neg;
			x_s1   <= arg[ArgW-1:0];
		end
	end

	assign word.valid = valid_s1;
	assign word.neg   = neg_s1;
	assign word.x     = x_s1;
	assign word.u     = COEF[0];

endmodule
`default_nettype wire

// ----- design/scp_cell.sv -----
`default_nettype none
module scp_cell
	import scp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic signed [AccW-1:0] coef,
	input  scp_word_t                   word_in,
	output scp_word_t                   word_out
);

	logic signed [ProdW-1:0] prod;
	logic signed [ProdW-1:0] biased;
	logic signed [AccW-1:0]  rounded;
	logic                    valid_s1;
	logic                    valid_s2;
	logic                    neg_s1;
	logic                    neg_s2;
	logic [ArgW-1:0]         x_s1;
	logic [ArgW-1:0]         x_s2;
	logic signed [ProdW-1:0] prod_s1;
	logic signed [AccW-1:0]  u_s2;

	assign prod = ProdW'(word_in.u) * ProdW'($signed({1'b0, word_in.x}));

	// Round to nearest with ties away from zero: a negative product takes one less bias.
	assign biased  = prod_s1 + (ProdW'(1) <<< (FracW - 1)) - ProdW'({1'b0, prod_s1[ProdW-1]});
	assign rounded = biased[FracW+AccW-1:FracW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= word_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			neg_s1  <= word_in.neg;
			x_s1    <= word_in.x;
			u_s2    <= rounded + coef;
			neg_s2  <= neg_s1;
			x_s2    <= x_s1;
		end
	end

	assign word_out.valid = valid_s2;
	assign word_out.neg   = neg_s2;
	assign word_out.x     = x_s2;
	assign word_out.u     = u_s2;

endmodule
`default_nettype wire

// ----- design/scp_out.sv -----
`default_nettype none
module scp_out
	import scp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  scp_word_t               word,
	output logic                    valid,
	output logic signed [ValueW-1:0] value
);

	logic signed [AccW-1:0] sat;
	logic signed [AccW-1:0] signed_val;
	logic                   valid_q;
	logic signed [ValueW-1:0] value_q;

	always_comb begin
		priority if (word.u > ONE_Q30) begin
			sat = ONE_Q30;
		end else if (word.u < -ONE_Q30) begin
			sat = -ONE_Q30;
		end else begin
			sat = word.u;
		end
		signed_val = word.neg ? -sat : sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= word.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= ValueW'(signed_val);
		end
	end

	assign valid = valid_q;
	assign value = value_q;

endmodule
`default_nettype wire

// ----- design/sine_cosine_polynomial_unit.sv -----
`default_nettype none
// Sine or cosine of a Q2.29 angle, returned in Q1.30 and saturated to +-1. The angle is
// clamped to +-pi, folded into [0, pi/2], and a degree-7 polynomial is evaluated by a
// chain of seven Horner cells, each a multiply stage followed by a round-and-add stage.
// A word is accepted every cycle while the output side takes results; each result passes
// through the fold stage, fourteen cell stages and the output register. The whole chain
// advances together, so a stalled output holds every stage.
module sine_cosine_polynomial_unit
	import scp_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     kind,
	input  wire logic signed [AngleW-1:0] angle,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [ValueW-1:0]      value
);

	localparam int NCells = NCoef - 1;

	logic      en;
	scp_word_t chain [NCells+1];

	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	scp_fold u_fold (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.valid  (in_valid),
		.kind   (kind),
		.angle  (angle),
		.word   (chain[0])
	);

	for (genvar k = 0; k < NCells; k++) begin : g_cell
		scp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.coef     (COEF[k+1]),
			.word_in  (chain[k]),
			.word_out (chain[k+1])
		);
	end

	scp_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.word   (chain[NCells]),
		.valid  (out_valid),
		.value  (value)
	);

endmodule
`default_nettype wire

// ----- design/scp_checker.sv -----
`default_nettype none
module scp_checker
	import scp_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic signed [ValueW-1:0] value
);

	// A held result word must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value))
		else $error("result word changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value <= ONE_Q30) && (value >= -ONE_Q30))
		else $error("result word outside plus or minus one");

	// The chain never refuses input while the output side is draining.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output ready");

	// An empty output register always lets the chain move.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no result waiting");

endmodule

bind sine_cosine_polynomial_unit scp_checker u_scp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value)
);
`default_nettype wire

// ----- verif/tb_sine_cosine_polynomial_unit.sv -----
`timescale 1ns / 1ps

module tb_sine_cosine_polynomial_unit;
	import scp_pkg::*;

	localparam logic KIND_SINE   = 1'b0;
	localparam logic KIND_COSINE = 1'b1;

	localparam longint PI_ANGLE      = 64'sd1686629713;
	localparam longint HALF_PI_ANGLE = 64'sd843314857;
	localparam longint UNIT_VALUE    = 64'sd1073741824;

	localparam int RANDOM_ANGLES = 1026;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 24;
	localparam int REPORT_LIMIT  = 10;
	localparam int NUM_PROBES    = 24;

	typedef struct {
		logic                     sel;
		logic signed [AngleW-1:0] ang;
		bit                       fixed;
		logic signed [ValueW-1:0] want;
	} probe_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     kind = KIND_SINE;
	logic signed [AngleW-1:0] angle = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [ValueW-1:0] value;

	// Travels with the payload so that the monitor knows which expectation to queue.
	bit                       tag_fixed = 1'b0;
	logic signed [ValueW-1:0] tag_want = '0;

	logic signed [ValueW-1:0] trig_due [$];
	probe_t                   probes [NUM_PROBES];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int bad_words = 0;
	int words_checked = 0;
	int angles_sent = 0;
	int sine_sent = 0;
	int clamped_sent = 0;

	sine_cosine_polynomial_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.angle    (angle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value    (value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Rounds p / 2^29 to nearest, ties away from zero.
	function automatic longint scale_down_q29(input longint p);
		longint mag;
		mag = (p < 0) ? -p : p;
		mag = (mag + 64'sd268435456) >>> 29;
		return (p < 0) ? -mag : mag;
	endfunction

	function automatic logic signed [ValueW-1:0] predict_trig(input logic sel,
			input logic signed [AngleW-1:0] ang);
		longint a;
		longint x;
		longint u;
		longint coef [8];
		logic   flip;
		coef = '{-64'sd147886, -64'sd219591, 64'sd9276365, -64'sd261228,
			-64'sd178844898, -64'sd24029, 64'sd1073743896, -64'sd38};
		a = ang;
		flip = 1'b0;
		if (a > PI_ANGLE)
			a = PI_ANGLE;
		if (a < -PI_ANGLE)
			a = -PI_ANGLE;
		x = (a < 0) ? -a : a;
		if (sel == KIND_SINE) begin
			flip = (a < 0);
			if (x > HALF_PI_ANGLE)
				x = PI_ANGLE - x;
		end else begin
			if (x > HALF_PI_ANGLE) begin
				flip = 1'b1;
				x = PI_ANGLE - x;
			end
			x = HALF_PI_ANGLE - x;
		end
		u = coef[0];
		for (int i = 1; i < 8; i++)
			u = coef[i] + scale_down_q29(u * x);
		if (u > UNIT_VALUE)
			u = UNIT_VALUE;
		if (u < -UNIT_VALUE)
			u = -UNIT_VALUE;
		if (flip)
			u = -u;
		return u[ValueW-1:0];
	endfunction

	// Most angles lie within +-pi, a share sit just around the folding points, and the
	// rest are raw 32-bit patterns that also reach the clamp.
	function automatic logic signed [AngleW-1:0] pick_angle();
		int unsigned pick;
		longint      base;
		pick = $urandom_range(99);
		if (pick < 55)
			return AngleW'(longint'($urandom_range(32'd3373259426)) - PI_ANGLE);
		if (pick < 80) begin
			case ($urandom_range(4))
				0: base = 0;
				1: base = HALF_PI_ANGLE;
				2: base = -HALF_PI_ANGLE;
				3: base = PI_ANGLE;
				default: base = -PI_ANGLE;
			endcase
			return AngleW'(base + longint'($urandom_range(64)) - 32);
		end
		return $urandom();
	endfunction

	task automatic send_word(input logic sel, input logic signed [AngleW-1:0] ang,
			input bit fixed, input logic signed [ValueW-1:0] want);
		in_valid <= 1'b1;
		kind <= sel;
		angle <= ang;
		tag_fixed <= fixed;
		tag_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_valid && out_ready) begin
			words_checked++;
			if (trig_due.size() == 0) begin
				bad_words++;
				if (bad_words <= REPORT_LIMIT)
					$display("result %0d (%0d) arrived with no angle pending",
						words_checked, value);
			end else begin
				if (value !== trig_due[0]) begin
					bad_words++;
					if (bad_words <= REPORT_LIMIT)
						$display("result %0d: expected %0d, got %0d",
							words_checked, trig_due[0], value);
				end
				void'(trig_due.pop_front());
			end
		end
		if (arst_n && in_valid && in_ready) begin
			trig_due.push_back(tag_fixed ? tag_want : predict_trig(kind, angle));
			angles_sent++;
			if (kind == KIND_SINE)
				sine_sent++;
			if (angle > PI_ANGLE || angle < -PI_ANGLE)
				clamped_sent++;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_sine_cosine_polynomial_unit: done, errors");
		$finish;
	end

	initial begin
		// Where the folded argument ends at zero the polynomial gives its constant term.
		probes = '{
			'{KIND_SINE,   32'sd0,           1'b1, -32'sd38},
			'{KIND_COSINE, 32'sd843314857,   1'b1, -32'sd38},
			'{KIND_COSINE, -32'sd843314857,  1'b1, -32'sd38},
			'{KIND_SINE,   32'sd1686629713,  1'b1, -32'sd38},
			'{KIND_SINE,   -32'sd1686629713, 1'b1, 32'sd38},
			'{KIND_SINE,   32'h7fffffff,     1'b1, -32'sd38},
			'{KIND_SINE,   32'h80000000,     1'b1, 32'sd38},
			'{KIND_COSINE, 32'sd0,           1'b0, '0},
			'{KIND_COSINE, 32'sd1686629713,  1'b0, '0},
			'{KIND_COSINE, -32'sd1686629713, 1'b0, '0},
			'{KIND_COSINE, 32'h7fffffff,     1'b0, '0},
			'{KIND_COSINE, 32'h80000000,     1'b0, '0},
			'{KIND_SINE,   32'sd843314857,   1'b0, '0},
			'{KIND_SINE,   -32'sd843314857,  1'b0, '0},
			'{KIND_SINE,   32'sd843314858,   1'b0, '0},
			'{KIND_SINE,   32'sd843314856,   1'b0, '0},
			'{KIND_COSINE, 32'sd843314858,   1'b0, '0},
			'{KIND_COSINE, 32'sd843314856,   1'b0, '0},
			'{KIND_SINE,   32'sd1,           1'b0, '0},
			'{KIND_SINE,   -32'sd1,          1'b0, '0},
			'{KIND_SINE,   32'sd1686629712,  1'b0, '0},
			'{KIND_COSINE, 32'sd1686629714,  1'b0, '0},
			'{KIND_SINE,   32'h55555555,     1'b0, '0},
			'{KIND_COSINE, 32'haaaaaaaa,     1'b0, '0}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				for (int i = 0; i < NUM_PROBES; i++)
					send_word(probes[i].sel, probes[i].ang, probes[i].fixed, probes[i].want);
			end
			for (int i = 0; i < RANDOM_ANGLES / 3; i++)
				send_word($urandom_range(1), pick_angle(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (trig_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("drove %0d angles (%0d sine, %0d cosine, %0d clamped beyond +-pi)",
			angles_sent, sine_sent, angles_sent - sine_sent, clamped_sent);
		$display("compared %0d results under three stall patterns, %0d bad",
			words_checked, bad_words);
		if (bad_words == 0)
			$display("tb_sine_cosine_polynomial_unit: done, clean");
		else
			$display("tb_sine_cosine_polynomial_unit: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
design/scp_pkg.sv
design/scp_fold.sv
design/scp_cell.sv
design/scp_out.sv
design/sine_cosine_polynomial_unit.sv
design/scp_checker.sv
verif/tb_sine_cosine_polynomial_unit.sv
